// File: hdl/iaw_pkg.sv
// ----------------------------------------------------------------------------
// iaw_pkg
// Shared types and constants of the in-flight acknowledge window.
// ----------------------------------------------------------------------------
package iaw_pkg;

	localparam int KEY_W    = 64;
	localparam int SIZE_W   = 32;
	localparam int BYTES_W  = 40;
	localparam int LIMIT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 224;
	localparam int OUT_W    = 120;

	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
	localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RST = 7'd64;
	localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST = 40'd134217728;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_ACK  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	localparam logic CFG_WINDOW_LIMIT = 1'b0;
	localparam logic CFG_BYTE_LIMIT   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PUSH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_MARK_RD,
		S_MARK_WR,
		S_POP_RD,
		S_POP_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic push;
		logic refuse;
		logic scan_init;
		logic scan_step;
		logic mark_init;
		logic mark_step;
		logic rd_head;
		logic pop;
		logic fail;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic req_ack;
		logic full;
		logic empty;
		logic end_hit;
		logic start_ok;
		logic scan_last;
		logic mark_last;
		logic pop_ok;
		logic out_busy;
	} dp_status_t;

endpackage

// File: hdl/iaw_ctrl.sv
// ----------------------------------------------------------------------------
// iaw_ctrl
// Sequencer for push, key scan, range mark and head pop.
// ----------------------------------------------------------------------------
module iaw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  iaw_pkg::dp_status_t st,
	output iaw_pkg::ctl_cmd_t   cmd
);
	import iaw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!st.req_ack) begin
					state_d = S_PUSH;
				end else if (st.empty) begin
					cmd.fail = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_PUSH: begin
				if (st.full) begin
					cmd.refuse = 1'b1;
				end else begin
					cmd.push = 1'b1;
				end
				state_d = S_DONE;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				// The first end match closes the scan; the start must be at or before it.
				if (st.end_hit) begin
					if (st.start_ok) begin
						cmd.mark_init = 1'b1;
						state_d       = S_MARK_RD;
					end else begin
						cmd.fail = 1'b1;
						state_d  = S_DONE;
					end
				end else if (st.scan_last) begin
					cmd.fail = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_MARK_RD: begin
				state_d = S_MARK_WR;
			end
			S_MARK_WR: begin
				cmd.mark_step = 1'b1;
				state_d       = st.mark_last ? S_POP_RD : S_MARK_RD;
			end
			S_POP_RD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_POP_CHK;
			end
			S_POP_CHK: begin
				if (st.pop_ok) begin
					cmd.pop = 1'b1;
					state_d = S_POP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/iaw_dpath.sv
// ----------------------------------------------------------------------------
// iaw_dpath
// Record memories, window pointers, byte total, configuration and result register.
// ----------------------------------------------------------------------------
module iaw_dpath #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tuser,
	input  logic [iaw_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [iaw_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [iaw_pkg::BYTES_W-1:0]   cfg_data,
	input  iaw_pkg::ctl_cmd_t             cmd,
	output iaw_pkg::dp_status_t           st
);
	import iaw_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int TW = SIZE_W + AW;
	localparam int BW = (TW > BYTES_W) ? TW : BYTES_W;
	localparam int EW = (CW > LIMIT_W) ? CW : LIMIT_W;

	logic [KEY_W-1:0]  key_mem   [WINDOW_DEPTH];
	logic [SIZE_W-1:0] size_mem  [WINDOW_DEPTH];
	logic              acked_mem [WINDOW_DEPTH];

	logic              req_q;
	logic [KEY_W-1:0]  off_q, start_key_q, end_key_q;
	logic [SIZE_W-1:0] size_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q, pos_q, start_pos_q, end_pos_q;
	logic              start_hit_q;
	logic [TW-1:0]     total_q;
	logic [LIMIT_W-1:0] window_limit_q;
	logic [BYTES_W-1:0] byte_limit_q;
	logic [STATUS_W-1:0] status_q;
	logic              popped_q;
	logic [KEY_W-1:0]  last_key_q;
	logic [KEY_W-1:0]  rd_key_q;
	logic [SIZE_W-1:0] rd_size_q;
	logic              rd_acked_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic [AW-1:0]     rd_addr, wr_addr;
	logic              acked_we, acked_wd;
	logic              start_now;
	logic [EW-1:0]     lim_ext, cnt_ext;
	logic [LIMIT_W-1:0] free_slots;
	logic [BW-1:0]     tot_ext;
	logic [BYTES_W-1:0] unacked;
	logic              over;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(WINDOW_DEPTH)) begin
			sum = sum - (CW+1)'(WINDOW_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_addr   = cmd.rd_head ? head_q : slot(head_q, pos_q);
	assign wr_addr   = cmd.push ? slot(head_q, count_q) : slot(head_q, pos_q);
	assign acked_we  = cmd.push || (cmd.mark_step && !rd_acked_q);
	assign acked_wd  = !cmd.push;
	assign start_now = (rd_key_q == start_key_q);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			key_mem[wr_addr]  <= off_q;
			size_mem[wr_addr] <= size_q;
		end
		if (acked_we) begin
			acked_mem[wr_addr] <= acked_wd;
		end
		rd_key_q   <= key_mem[rd_addr];
		rd_size_q  <= size_mem[rd_addr];
		rd_acked_q <= acked_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q       <= s_tuser;
			off_q       <= s_tdata[63:0];
			size_q      <= s_tdata[95:64];
			start_key_q <= s_tdata[159:96];
			end_key_q   <= s_tdata[223:160];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			total_q        <= '0;
			pos_q          <= '0;
			start_pos_q    <= '0;
			end_pos_q      <= '0;
			start_hit_q    <= 1'b0;
			status_q       <= ST_OK;
			popped_q       <= 1'b0;
			last_key_q     <= '0;
			window_limit_q <= WINDOW_LIMIT_RST;
			byte_limit_q   <= BYTE_LIMIT_RST;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_WINDOW_LIMIT) begin
					window_limit_q <= cfg_data[LIMIT_W-1:0];
				end else begin
					byte_limit_q <= cfg_data;
				end
			end
			if (cmd.load_in) begin
				status_q   <= ST_OK;
				popped_q   <= 1'b0;
				last_key_q <= '0;
			end
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
				total_q <= total_q + TW'(size_q);
			end
			if (cmd.refuse) begin
				status_q <= ST_FULL;
			end
			if (cmd.fail) begin
				status_q <= ST_NOT_FOUND;
			end
			if (cmd.scan_init) begin
				pos_q       <= '0;
				start_hit_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (start_now) begin
					start_pos_q <= pos_q;
					start_hit_q <= 1'b1;
				end
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.mark_init) begin
				end_pos_q <= pos_q;
				pos_q     <= start_now ? pos_q : start_pos_q;
			end
			if (cmd.mark_step) begin
				if (!rd_acked_q) begin
					total_q <= total_q - TW'(rd_size_q);
				end
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.pop) begin
				last_key_q <= rd_key_q;
				popped_q   <= 1'b1;
				head_q     <= (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q    <= count_q - 1'b1;
			end
		end
	end

	assign lim_ext    = EW'(window_limit_q);
	assign cnt_ext    = EW'(count_q);
	assign free_slots = (lim_ext > cnt_ext) ? LIMIT_W'(lim_ext - cnt_ext) : '0;
	assign tot_ext    = BW'(total_q);
	assign unacked    = (tot_ext > BW'(BYTES_MAX)) ? BYTES_MAX : tot_ext[BYTES_W-1:0];
	assign over       = tot_ext > BW'(byte_limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {5'd0, over, unacked, free_slots, last_key_q, popped_q, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign st.req_ack   = (req_q == REQ_ACK);
	assign st.full      = (cnt_ext >= lim_ext) || (count_q == CW'(WINDOW_DEPTH));
	assign st.empty     = (count_q == '0);
	assign st.end_hit   = (rd_key_q == end_key_q);
	assign st.start_ok  = start_hit_q || start_now;
	assign st.scan_last = (pos_q == count_q - 1'b1);
	assign st.mark_last = (pos_q == end_pos_q);
	assign st.pop_ok    = (count_q != '0) && rd_acked_q;
	assign st.out_busy  = m_tvalid_q && !m_tready;

endmodule

// File: hdl/inflight_ack_window.sv
// ----------------------------------------------------------------------------
// inflight_ack_window
// Ordered window of in-flight records with range acknowledge and head pop.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser 0 pushes the record in tdata, tuser 1
// acknowledges the key range in tdata. Each request yields one result on the
// m_ stream. Register writes arrive on the cfg_ channel, index 0 the window
// limit and index 1 the byte limit; they are taken in any cycle.
// A push passes through dispatch and the push state before its result is
// loaded. An ack scans the records up to the end key, marks the records of
// the range as acked and then pops acked records from the head; the single
// read port of the record memories gives each record its own read state
// before it is checked. A failed ack skips the mark and pop steps.
// One request is in work at a time; the next is accepted once the current
// result sits in the output register, even if the receiver stalls it. That
// next result then waits in the engine until the output register is free.
// Reset empties the window, clears the byte total and restores both limits.
// ----------------------------------------------------------------------------
module inflight_ack_window #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic                        s_tuser,   // req_type
	// item_offset, item_size, ack_start, ack_end
	input  logic [iaw_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status, popped_any, popped_key, free_slots, unacked_bytes, over_byte_limit
	output logic [iaw_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [iaw_pkg::BYTES_W-1:0] cfg_data
);
	import iaw_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	iaw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	iaw_dpath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

// File: hdl/iaw_checker.sv
// ----------------------------------------------------------------------------
// iaw_checker
// Port-level checks of the in-flight acknowledge window.
// ----------------------------------------------------------------------------
module iaw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [iaw_pkg::OUT_W-1:0]   m_tdata
);
	import iaw_pkg::*;

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	// Only a successful ack pops records.
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK)
		else $error("pop reported with failing status");

	a_no_pop_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[66:3] == '0)
		else $error("acked offset set without pop");

	// A request is taken only after the previous one has left the engine.
	a_one_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted twice in a row");

endmodule

bind inflight_ack_window iaw_checker u_iaw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
